// File: rtl/cdf_pkg.sv
// ----------------------------------------------------------------------------
// cdf_pkg: shared definitions of the CRC-8 packet deframer
// Sizes, register indexes, status codes, queue and RAM types, CRC-8 step.
// ----------------------------------------------------------------------------
package cdf_pkg;

	localparam int MAX_PAYLOAD = 32;
	localparam int PAY_AW      = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
	localparam int RAM_AW      = PAY_AW + 1;
	localparam int RAM_DEPTH   = 1 << RAM_AW;
	localparam int CNT_W       = 6;
	localparam int LIM_W       = 7;
	localparam int CFG_IDX_W   = 1;
	localparam int CMDQ_AW     = 1;
	localparam int CMDQ_DEPTH  = 1 << CMDQ_AW;

	localparam logic [7:0]       CRC_POLY    = 8'h31;
	localparam logic [7:0]       CRC_INIT    = 8'h00;
	localparam logic [7:0]       SYNC_RESET  = 8'hAA;
	localparam logic [CNT_W-1:0] LIMIT_RESET = CNT_W'(32);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SYNC  = 1'b0,
		REG_LIMIT = 1'b1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_GOOD = 2'd0,
		ST_CRC  = 2'd1,
		ST_LEN  = 2'd2
	} status_t;

	// One entry of the command queue between front and back
	typedef struct packed {
		status_t    status;
		logic [7:0] id;
		logic [7:0] length;
		logic       bank;
	} cmd_t;

	typedef struct packed {
		logic              en;
		logic [RAM_AW-1:0] addr;
		logic [7:0]        data;
	} wr_t;

	// Payload bank handed back once its replay has been read out
	typedef struct packed {
		logic valid;
		logic bank;
	} rel_t;

	function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int k = 0; k < 8; k++) begin
			c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
		end
		return c;
	endfunction

endpackage

// File: rtl/cdf_ifs.sv
// ----------------------------------------------------------------------------
// cdf_ifs: channel interfaces of the CRC-8 packet deframer
// Received byte channel, result channel and register write channel.
// ----------------------------------------------------------------------------
interface cdf_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;
	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface cdf_res_if;
	logic       valid;
	logic       ready;
	logic [1:0] frame_status;
	logic [7:0] message_id;
	logic [7:0] message_length;
	logic       has_payload;
	logic [4:0] byte_position;
	logic [7:0] payload_byte;
	logic       last;
	modport source (output valid, output frame_status, output message_id,
		output message_length, output has_payload, output byte_position,
		output payload_byte, output last, input ready);
	modport sink (input valid, input frame_status, input message_id,
		input message_length, input has_payload, input byte_position,
		input payload_byte, input last, output ready);
endinterface

interface cdf_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [cdf_pkg::CFG_IDX_W-1:0] index;
	logic [7:0]                    data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// File: rtl/crc8_packet_deframer.sv
// ----------------------------------------------------------------------------
// crc8_packet_deframer: sync/id/length/payload/CRC-8 frame receiver
// Top level: register file, front parser, command queue, payload RAM, back.
// ----------------------------------------------------------------------------
// The parser takes one received byte per cycle. It pauses only when the
// two-entry command queue is full or when a payload byte would land in a RAM
// bank whose frame is still being replayed; the payload RAM holds two banks
// of MAX_PAYLOAD bytes, so one frame can fill while the previous one drains.
// A frame ends in one result, or in a replay of n payload bytes from the
// command queue (a registered RAM read of the first byte, then one result
// per cycle while the output is taken). Registers sync_value (index 0) and
// payload_limit (index 1) are written over the configuration channel, which
// is always ready. The RAM needs no clearing pass after reset.
module crc8_packet_deframer (
	input  logic       clk,
	input  logic       arst_n,
	cdf_rx_if.sink     rx,
	cdf_res_if.source  res,
	cdf_cfg_if.sink    cfg
);

	logic [7:0]                 sync_q;
	logic [cdf_pkg::CNT_W-1:0]  limit_q;

	logic                       push;
	logic                       pop;
	logic                       cmdq_full;
	logic                       cmdq_empty;
	cdf_pkg::cmd_t              push_cmd;
	cdf_pkg::cmd_t              head;
	cdf_pkg::wr_t               wr;
	cdf_pkg::rel_t              rel;
	logic                       rd_en;
	logic [cdf_pkg::RAM_AW-1:0] rd_addr;
	logic [7:0]                 rd_data;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_q  <= cdf_pkg::SYNC_RESET;
			limit_q <= cdf_pkg::LIMIT_RESET;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cdf_pkg::cfg_reg_t'(cfg.index))
				cdf_pkg::REG_SYNC:  sync_q  <= cfg.data;
				cdf_pkg::REG_LIMIT: limit_q <= cfg.data[cdf_pkg::CNT_W-1:0];
				default:            sync_q  <= sync_q;
			endcase
		end
	end

	cdf_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.rx            (rx),
		.sync_value    (sync_q),
		.payload_limit (limit_q),
		.cmdq_full     (cmdq_full),
		.push          (push),
		.push_cmd      (push_cmd),
		.wr            (wr),
		.rel           (rel)
	);

	cdf_cmd_fifo u_cmdq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.full     (cmdq_full),
		.empty    (cmdq_empty)
	);

	cdf_ram #(
		.WIDTH (8),
		.DEPTH (cdf_pkg::RAM_DEPTH)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr.en),
		.wr_addr (wr.addr),
		.wr_data (wr.data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	cdf_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.empty   (cmdq_empty),
		.head    (head),
		.pop     (pop),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.rel     (rel),
		.res     (res)
	);

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !cmdq_full)
		else $error("command pushed into a full queue");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !cmdq_empty)
		else $error("command popped from an empty queue");

	a_single_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && !res.has_payload) |-> res.last)
		else $error("status result without last mark");

	a_replay_good: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.has_payload) |-> (res.frame_status == cdf_pkg::ST_GOOD))
		else $error("payload byte carried with error status");

endmodule

// File: rtl/cdf_ram.sv
// ----------------------------------------------------------------------------
// cdf_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module cdf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		// hold read data while no read is issued
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// File: rtl/cdf_front.sv
// ----------------------------------------------------------------------------
// cdf_front: frame parser
// Hunts for sync, takes id, length, payload and CRC byte, stores the payload
// in one of two RAM banks and queues one command per finished frame.
// ----------------------------------------------------------------------------
module cdf_front (
	input  logic                      clk,
	input  logic                      arst_n,
	cdf_rx_if.sink                    rx,
	input  logic [7:0]                sync_value,
	input  logic [cdf_pkg::CNT_W-1:0] payload_limit,
	input  logic                      cmdq_full,
	output logic                      push,
	output cdf_pkg::cmd_t             push_cmd,
	output cdf_pkg::wr_t              wr,
	input  cdf_pkg::rel_t             rel
);

	typedef enum logic [4:0] {
		PH_SYNC = 5'b00001,
		PH_ID   = 5'b00010,
		PH_LEN  = 5'b00100,
		PH_PAY  = 5'b01000,
		PH_CRC  = 5'b10000
	} phase_t;

	phase_t                    phase_q;
	logic [7:0]                id_q;
	logic [cdf_pkg::CNT_W-1:0] len_q;
	logic [cdf_pkg::CNT_W-1:0] cnt_q;
	logic [7:0]                crc_q;
	logic                      bank_q;
	logic [1:0]                busy_q;

	logic                      accept;
	logic [7:0]                b;
	logic [cdf_pkg::LIM_W-1:0] lim;
	logic                      too_long;
	logic [cdf_pkg::CNT_W-1:0] cnt_next;
	logic                      crc_ok;
	logic                      set_busy;

	assign b        = rx.rx_byte;
	assign rx.ready = !cmdq_full && !((phase_q == PH_PAY) && busy_q[bank_q]);
	assign accept   = rx.valid && rx.ready;

	assign lim = (cdf_pkg::LIM_W'(payload_limit) < cdf_pkg::LIM_W'(cdf_pkg::MAX_PAYLOAD)) ?
		cdf_pkg::LIM_W'(payload_limit) : cdf_pkg::LIM_W'(cdf_pkg::MAX_PAYLOAD);
	assign too_long = b > 8'(lim);
	assign cnt_next = cnt_q + cdf_pkg::CNT_W'(1);
	assign crc_ok   = (crc_q == b);

	always_comb begin
		push     = 1'b0;
		set_busy = 1'b0;
		push_cmd = '{status: cdf_pkg::ST_GOOD, id: id_q, length: 8'(len_q), bank: bank_q};
		if (accept && (phase_q == PH_LEN) && too_long) begin
			push            = 1'b1;
			push_cmd.status = cdf_pkg::ST_LEN;
			push_cmd.length = b;
		end else if (accept && (phase_q == PH_CRC)) begin
			push            = 1'b1;
			push_cmd.status = crc_ok ? cdf_pkg::ST_GOOD : cdf_pkg::ST_CRC;
			set_busy        = crc_ok && (len_q != '0);
		end
	end

	assign wr.en   = accept && (phase_q == PH_PAY);
	assign wr.addr = {bank_q, cnt_q[cdf_pkg::PAY_AW-1:0]};
	assign wr.data = b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SYNC;
			id_q    <= '0;
			len_q   <= '0;
			cnt_q   <= '0;
			crc_q   <= cdf_pkg::CRC_INIT;
			bank_q  <= 1'b0;
		end else if (accept) begin
			unique case (phase_q)
				PH_ID: begin
					id_q    <= b;
					crc_q   <= cdf_pkg::crc8_byte(cdf_pkg::CRC_INIT, b);
					phase_q <= PH_LEN;
				end
				PH_LEN: begin
					cnt_q <= '0;
					if (too_long) begin
						phase_q <= PH_SYNC;
					end else begin
						len_q   <= b[cdf_pkg::CNT_W-1:0];
						crc_q   <= cdf_pkg::crc8_byte(crc_q, b);
						phase_q <= (b == 8'd0) ? PH_CRC : PH_PAY;
					end
				end
				PH_PAY: begin
					crc_q <= cdf_pkg::crc8_byte(crc_q, b);
					cnt_q <= cnt_next;
					if (cnt_next >= len_q) begin
						phase_q <= PH_CRC;
					end
				end
				PH_CRC: begin
					// swap banks so the next frame fills while this one replays
					if (set_busy) begin
						bank_q <= !bank_q;
					end
					phase_q <= PH_SYNC;
				end
				default: begin
					phase_q <= (b == sync_value) ? PH_ID : PH_SYNC;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= '0;
		end else begin
			for (int k = 0; k < 2; k++) begin
				if (set_busy && (bank_q == 1'(k))) begin
					busy_q[k] <= 1'b1;
				end else if (rel.valid && (rel.bank == 1'(k))) begin
					busy_q[k] <= 1'b0;
				end
			end
		end
	end

endmodule

// File: rtl/cdf_cmd_fifo.sv
// ----------------------------------------------------------------------------
// cdf_cmd_fifo: command queue
// Short first-in first-out queue of frame commands between front and back.
// ----------------------------------------------------------------------------
module cdf_cmd_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  cdf_pkg::cmd_t push_cmd,
	input  logic          pop,
	output cdf_pkg::cmd_t head,
	output logic          full,
	output logic          empty
);

	cdf_pkg::cmd_t              mem_q [cdf_pkg::CMDQ_DEPTH];
	logic [cdf_pkg::CMDQ_AW-1:0] wptr_q;
	logic [cdf_pkg::CMDQ_AW-1:0] rptr_q;
	logic [cdf_pkg::CMDQ_AW:0]   cnt_q;

	assign head  = mem_q[rptr_q];
	assign full  = (cnt_q == (cdf_pkg::CMDQ_AW + 1)'(cdf_pkg::CMDQ_DEPTH));
	assign empty = (cnt_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// File: rtl/cdf_back.sv
// ----------------------------------------------------------------------------
// cdf_back: result generator
// Takes queued commands and issues results: one status result, or a replay
// of the stored payload read from RAM one byte per cycle while results are taken.
// ----------------------------------------------------------------------------
module cdf_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       empty,
	input  cdf_pkg::cmd_t              head,
	output logic                       pop,
	output logic                       rd_en,
	output logic [cdf_pkg::RAM_AW-1:0] rd_addr,
	input  logic [7:0]                 rd_data,
	output cdf_pkg::rel_t              rel,
	cdf_res_if.source                  res
);

	typedef enum logic [1:0] {
		B_IDLE = 2'b01,
		B_DATA = 2'b10
	} bstate_t;

	bstate_t                   state_q;
	cdf_pkg::cmd_t             cmd_q;
	logic [cdf_pkg::CNT_W-1:0] idx_q;
	logic [cdf_pkg::CNT_W-1:0] idx_next;

	logic                      out_valid_q;
	logic [1:0]                out_status_q;
	logic [7:0]                out_id_q;
	logic [7:0]                out_len_q;
	logic                      out_has_q;
	logic [4:0]                out_pos_q;
	logic [7:0]                out_byte_q;
	logic                      out_last_q;

	logic                      out_free;
	logic                      replay;
	logic                      load_single;
	logic                      load_byte;
	logic                      is_last;

	assign out_free = !out_valid_q || res.ready;
	assign replay   = (head.status == cdf_pkg::ST_GOOD) && (head.length != 8'd0);
	assign idx_next = idx_q + cdf_pkg::CNT_W'(1);
	assign is_last  = (8'(idx_next) == cmd_q.length);

	always_comb begin
		pop         = 1'b0;
		rd_en       = 1'b0;
		rd_addr     = {head.bank, {cdf_pkg::PAY_AW{1'b0}}};
		load_single = 1'b0;
		load_byte   = 1'b0;
		rel         = '{valid: 1'b0, bank: cmd_q.bank};
		unique case (state_q)
			B_DATA: begin
				if (out_free) begin
					load_byte = 1'b1;
					if (is_last) begin
						rel.valid = 1'b1;
					end else begin
						// fetch the next byte while this one goes out
						rd_en   = 1'b1;
						rd_addr = {cmd_q.bank, idx_next[cdf_pkg::PAY_AW-1:0]};
					end
				end
			end
			default: begin
				if (!empty) begin
					if (replay) begin
						pop   = 1'b1;
						rd_en = 1'b1;
					end else if (out_free) begin
						pop         = 1'b1;
						load_single = 1'b1;
					end
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (load_single || load_byte) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				B_DATA: begin
					if (load_byte && is_last) begin
						state_q <= B_IDLE;
					end
				end
				default: begin
					state_q <= (pop && replay) ? B_DATA : B_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop && replay) begin
			cmd_q <= head;
			idx_q <= '0;
		end else if (load_byte) begin
			idx_q <= idx_next;
		end
		if (load_single) begin
			out_status_q <= head.status;
			out_id_q     <= head.id;
			out_len_q    <= head.length;
			out_has_q    <= 1'b0;
			out_pos_q    <= '0;
			out_byte_q   <= '0;
			out_last_q   <= 1'b1;
		end else if (load_byte) begin
			out_status_q <= cdf_pkg::ST_GOOD;
			out_id_q     <= cmd_q.id;
			out_len_q    <= cmd_q.length;
			out_has_q    <= 1'b1;
			out_pos_q    <= idx_q[4:0];
			out_byte_q   <= rd_data;
			out_last_q   <= is_last;
		end
	end

	assign res.valid          = out_valid_q;
	assign res.frame_status   = out_status_q;
	assign res.message_id     = out_id_q;
	assign res.message_length = out_len_q;
	assign res.has_payload    = out_has_q;
	assign res.byte_position  = out_pos_q;
	assign res.payload_byte   = out_byte_q;
	assign res.last           = out_last_q;

endmodule
